// ===== design/tnso_pkg.sv =====
// Shared types and opcode constants for the TCP NAT sequence offset tracker.
package tnso_pkg;

   // Item opcodes
   localparam logic OP_RESIZE = 1'b0;
   localparam logic OP_ADJUST = 1'b1;

   // One per-direction offset record
   typedef struct packed {
      logic [31:0] position;
      logic [31:0] prior;
      logic [31:0] later;
   } record_type;

   // Input item payload
   typedef struct packed {
      logic        opcode;
      logic [7:0]  conn_index;
      logic        direction;
      logic [31:0] seq_number;
      logic [31:0] ack_number;
      logic [15:0] old_checksum;
      logic [15:0] old_length;
      logic [15:0] new_length;
   } req_type;

   // Result item payload
   typedef struct packed {
      logic [31:0] new_seq;
      logic [31:0] new_ack;
      logic [15:0] new_checksum;
      logic        recorded;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;
      logic index;
      logic fetch;
      logic update;
      logic csum_a;
      logic csum_b;
      logic clear_step;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_done;
   } status_type;

endpackage

// ===== design/tnso_req_if.sv =====
// Request channel interface: valid/ready handshake plus item fields.
interface tnso_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [7:0]  conn_index;
   logic        direction;
   logic [31:0] seq_number;
   logic [31:0] ack_number;
   logic [15:0] old_checksum;
   logic [15:0] old_length;
   logic [15:0] new_length;

   modport source (
      output valid, opcode, conn_index, direction, seq_number, ack_number,
             old_checksum, old_length, new_length,
      input  ready
   );
   modport sink (
      input  valid, opcode, conn_index, direction, seq_number, ack_number,
             old_checksum, old_length, new_length,
      output ready
   );
endinterface

// ===== design/tnso_rsp_if.sv =====
// Response channel interface: valid/ready handshake plus result fields.
interface tnso_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] new_seq;
   logic [31:0] new_ack;
   logic [15:0] new_checksum;
   logic        recorded;

   modport source (
      output valid, new_seq, new_ack, new_checksum, recorded,
      input  ready
   );
   modport sink (
      input  valid, new_seq, new_ack, new_checksum, recorded,
      output ready
   );
endinterface

// ===== design/tcp_nat_seq_offset_tracker.sv =====
// Top level of the TCP NAT sequence offset tracker.
//
//   Channel  Dir  Handshake       Payload
//   req_ch   in   valid / ready   opcode, conn_index, direction, seq, ack,
//                                 old_checksum, old_length, new_length
//   rsp_ch   out  valid / ready   new_seq, new_ack, new_checksum, recorded
//
// One item at a time: a new item is taken only once the result of the last one
// has been accepted. Each item goes through the read, compare, update and write
// of one record pair followed by two checksum patch steps before its result is
// valid. After reset a clearing pass zeroes both stores, with req_ch.ready low.
// A stalled response holds the result and keeps req_ch.ready low until it is
// taken.
module tcp_nat_seq_offset_tracker #(
   parameter int CONNECTIONS = 256
) (
   input  logic         clock,
   input  logic         reset,
   tnso_req_if.sink     req_ch,
   tnso_rsp_if.source   rsp_ch
);
   import tnso_pkg::*;

   cmd_type    cmd;
   status_type status;
   req_type    req_data;
   rsp_type    rsp_data;

   // Pack the request payload
   always_comb begin
      req_data.opcode       = req_ch.opcode;
      req_data.conn_index   = req_ch.conn_index;
      req_data.direction    = req_ch.direction;
      req_data.seq_number   = req_ch.seq_number;
      req_data.ack_number   = req_ch.ack_number;
      req_data.old_checksum = req_ch.old_checksum;
      req_data.old_length   = req_ch.old_length;
      req_data.new_length   = req_ch.new_length;
   end

   tnso_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   tnso_dpath #(.CONNECTIONS(CONNECTIONS)) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // Drive the response payload
   assign rsp_ch.new_seq      = rsp_data.new_seq;
   assign rsp_ch.new_ack      = rsp_data.new_ack;
   assign rsp_ch.new_checksum = rsp_data.new_checksum;
   assign rsp_ch.recorded     = rsp_data.recorded;

endmodule

// ===== design/tnso_mem.sv =====
// Offset record store: one write port, one registered read port.
module tnso_mem #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  tnso_pkg::record_type wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output tnso_pkg::record_type rd_data
);
   import tnso_pkg::*;

   record_type mem_ff [DEPTH];
   record_type rd_data_ff;

   // Write the addressed record
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read data, hold it between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tnso_ctrl.sv =====
// Controller state machine: clearing pass, item sequencing and handshakes.
module tnso_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tnso_pkg::cmd_type    cmd,
   input  tnso_pkg::status_type status
);
   import tnso_pkg::*;

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_INDEX  = 8'b0000_0100,
      ST_FETCH  = 8'b0000_1000,
      ST_UPDATE = 8'b0001_0000,
      ST_CSUM_A = 8'b0010_0000,
      ST_CSUM_B = 8'b0100_0000,
      ST_RESP   = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_INDEX;
         end
         ST_INDEX:  state_in = ST_FETCH;
         ST_FETCH:  state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_CSUM_A;
         ST_CSUM_A: state_in = ST_CSUM_B;
         ST_CSUM_B: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Handshakes
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   // Datapath commands
   always_comb begin
      cmd            = '0;
      cmd.accept     = (state_ff == ST_IDLE) && req_valid;
      cmd.index      = (state_ff == ST_INDEX);
      cmd.fetch      = (state_ff == ST_FETCH);
      cmd.update     = (state_ff == ST_UPDATE);
      cmd.csum_a     = (state_ff == ST_CSUM_A);
      cmd.csum_b     = (state_ff == ST_CSUM_B);
      cmd.clear_step = (state_ff == ST_CLEAR);
   end

endmodule

// ===== design/tnso_dpath.sv =====
// Datapath: record stores, serial compares, offset update and checksum patch.
module tnso_dpath #(
   parameter int CONNECTIONS = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tnso_pkg::cmd_type    cmd,
   output tnso_pkg::status_type status,
   input  tnso_pkg::req_type    req_data,
   output tnso_pkg::rsp_type    rsp_data
);
   import tnso_pkg::*;

   localparam int AW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
   localparam logic [AW-1:0] LAST_ENTRY = AW'(CONNECTIONS - 1);

   // One's-complement incremental patch of one 32-bit word
   function automatic logic [15:0] csum_patch(input logic [15:0] check,
                                              input logic [31:0] old_w,
                                              input logic [31:0] new_w);
      logic [15:0] nc;
      logic [31:0] inv;
      logic [18:0] s;
      logic [16:0] t;
      logic [15:0] u;
      nc  = ~check;
      inv = ~old_w;
      s   = 19'(nc) + 19'(inv[31:16]) + 19'(inv[15:0])
          + 19'(new_w[31:16]) + 19'(new_w[15:0]);
      t   = 17'(s[15:0]) + 17'(s[18:16]);
      u   = t[15:0] + 16'(t[16]);
      return ~u;
   endfunction

   req_type        req_ff;
   logic [AW-1:0]  idx_ff;
   logic [AW-1:0]  clr_cnt_ff;
   logic [31:0]    delta_ff;
   logic           seq_after_ff;
   logic           upd_ff;
   logic [31:0]    new_later_ff;
   logic [31:0]    a_ff;
   logic [31:0]    nseq_ff;
   logic           ack_after_ff;
   logic [31:0]    nack_alt_ff;
   logic [31:0]    nack_ff;
   logic [15:0]    c1_ff;
   rsp_type        rsp_ff;

   logic [7:0]     idx_red;
   logic [AW-1:0]  idx_in;
   record_type     rec0;
   record_type     rec1;
   record_type     me_rec;
   record_type     oth_rec;
   record_type     wr_rec;
   logic [AW-1:0]  wr_addr;
   logic           wr_own;
   logic           wr_en0;
   logic           wr_en1;
   logic [31:0]    pos_diff;
   logic [31:0]    ack_diff;
   logic [31:0]    nack;
   logic [15:0]    c2;

   // Capture the item on transfer
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
   end

   // Reduce the connection index modulo the record count
   always_comb begin
      idx_red = req_ff.conn_index;
      for (int k = 8; k >= 0; k--) begin
         if ((CONNECTIONS << k) <= 255) begin
            if (int'(idx_red) >= (CONNECTIONS << k)) begin
               idx_red = idx_red - 8'(CONNECTIONS << k);
            end
         end
      end
      idx_in = AW'(idx_red);
   end

   always_ff @(posedge clock) begin
      if (cmd.index) begin
         idx_ff   <= idx_in;
         delta_ff <= 32'(req_ff.new_length) - 32'(req_ff.old_length);
      end
   end

   // Clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step && clr_cnt_ff != LAST_ENTRY) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   assign status.clear_done = (clr_cnt_ff == LAST_ENTRY);

   // Record stores, one per direction
   assign wr_own  = cmd.update && (req_ff.opcode == OP_RESIZE) && upd_ff;
   assign wr_en0  = cmd.clear_step || (wr_own && !req_ff.direction);
   assign wr_en1  = cmd.clear_step || (wr_own && req_ff.direction);
   assign wr_addr = cmd.clear_step ? clr_cnt_ff : idx_ff;

   always_comb begin
      if (cmd.clear_step) begin
         wr_rec = '0;
      end else begin
         wr_rec.position = req_ff.seq_number;
         wr_rec.prior    = me_rec.later;
         wr_rec.later    = new_later_ff;
      end
   end

   tnso_mem #(.DEPTH(CONNECTIONS), .ADDR_W(AW)) u_mem_orig (
      .clock   (clock),
      .wr_en   (wr_en0),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_en   (cmd.index),
      .rd_addr (idx_in),
      .rd_data (rec0)
   );

   tnso_mem #(.DEPTH(CONNECTIONS), .ADDR_W(AW)) u_mem_reply (
      .clock   (clock),
      .wr_en   (wr_en1),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_en   (cmd.index),
      .rd_addr (idx_in),
      .rd_data (rec1)
   );

   assign me_rec  = req_ff.direction ? rec1 : rec0;
   assign oth_rec = req_ff.direction ? rec0 : rec1;

   // Stage one: own serial compare, resize decision, ack shift by prior offset
   assign pos_diff = me_rec.position - req_ff.seq_number;

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         seq_after_ff <= pos_diff[31];
         upd_ff       <= (me_rec.prior == me_rec.later) || pos_diff[31];
         new_later_ff <= me_rec.later + delta_ff;
         a_ff         <= req_ff.ack_number - oth_rec.prior;
      end
   end

   // Stage two: shift seq, compare ack against the other position
   assign ack_diff = oth_rec.position - a_ff;

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         nseq_ff      <= req_ff.seq_number + (seq_after_ff ? me_rec.later : me_rec.prior);
         ack_after_ff <= ack_diff[31];
         nack_alt_ff  <= req_ff.ack_number - oth_rec.later;
      end
   end

   // Checksum patch for the ack word
   assign nack = ack_after_ff ? nack_alt_ff : a_ff;

   always_ff @(posedge clock) begin
      if (cmd.csum_a) begin
         nack_ff <= nack;
         c1_ff   <= csum_patch(req_ff.old_checksum, req_ff.ack_number, nack);
      end
   end

   // Checksum patch for the seq word, then form the result
   assign c2 = csum_patch(c1_ff, req_ff.seq_number, nseq_ff);

   always_ff @(posedge clock) begin
      if (cmd.csum_b) begin
         if (req_ff.opcode == OP_ADJUST) begin
            rsp_ff.new_seq      <= nseq_ff;
            rsp_ff.new_ack      <= nack_ff;
            rsp_ff.new_checksum <= c2;
            rsp_ff.recorded     <= 1'b0;
         end else begin
            rsp_ff.new_seq      <= req_ff.seq_number;
            rsp_ff.new_ack      <= req_ff.ack_number;
            rsp_ff.new_checksum <= req_ff.old_checksum;
            rsp_ff.recorded     <= upd_ff;
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== dv/tb_tcp_nat_seq_offset_tracker.sv =====
// Testbench for the TCP NAT sequence offset tracker: directed and random headers, self-checked.
module tb_tcp_nat_seq_offset_tracker;
   timeunit 1ns;
   timeprecision 1ps;

   import tnso_pkg::*;

   localparam int RANDOM_HEADERS = 1300;
   localparam int QUIET_LIMIT    = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tnso_req_if req_ch ();
   tnso_rsp_if rsp_ch ();

   tcp_nat_seq_offset_tracker #(.CONNECTIONS(256)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Headers waiting to be sent and rewrites waiting to come back
   req_type pending_headers[$];
   rsp_type expected_rewrites[$];

   // Own copy of the per-direction offset records
   record_type offset_records [0:511];

   // Per-record sequence cursor used to build well-formed flows
   logic [31:0] flow_seq [0:511];
   logic [7:0]  hot_conns [0:5] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd254, 8'd255};

   req_type     req_item = '0;
   int          send_gap = 0;
   bit          send_steady = 1'b0;
   int          recv_wait = 0;
   bit          recv_steady = 1'b0;
   int          quiet_cycles = 0;
   int          fail_count = 0;
   int          adjust_count = 0;
   int          recorded_count = 0;
   int          kept_count = 0;
   rsp_type     due_rewrite;

   always #10 clock = ~clock;

   // Present the held header on the request channel
   assign req_ch.opcode       = req_item.opcode;
   assign req_ch.conn_index   = req_item.conn_index;
   assign req_ch.direction    = req_item.direction;
   assign req_ch.seq_number   = req_item.seq_number;
   assign req_ch.ack_number   = req_item.ack_number;
   assign req_ch.old_checksum = req_item.old_checksum;
   assign req_ch.old_length   = req_item.old_length;
   assign req_ch.new_length   = req_item.new_length;

   // Serial-number order: x strictly before y
   function automatic bit seq_before(logic [31:0] x, logic [31:0] y);
      logic [31:0] diff;
      diff = x - y;
      return diff[31];
   endfunction

   // Fold one 32-bit word change into a one's-complement checksum
   function automatic logic [15:0] csum_patch(logic [15:0] check, logic [31:0] old_word,
                                              logic [31:0] new_word);
      logic [31:0] inv;
      logic [31:0] acc;
      inv = ~old_word;
      acc = {16'h0, ~check} + inv[31:16] + inv[15:0] + new_word[31:16] + new_word[15:0];
      while (acc > 32'hFFFF)
         acc = acc[15:0] + acc[31:16];
      return ~acc[15:0];
   endfunction

   // Compute the rewritten header and update the offset records
   function automatic rsp_type rewrite_header(req_type hdr);
      logic [8:0]  own;
      logic [8:0]  peer;
      logic [31:0] ack_back;
      rsp_type     rw;
      own  = {hdr.conn_index, hdr.direction};
      peer = {hdr.conn_index, ~hdr.direction};
      rw   = '0;
      if (hdr.opcode == OP_RESIZE) begin
         rw.new_seq      = hdr.seq_number;
         rw.new_ack      = hdr.ack_number;
         rw.new_checksum = hdr.old_checksum;
         if (offset_records[own].prior == offset_records[own].later ||
             seq_before(offset_records[own].position, hdr.seq_number)) begin
            offset_records[own].position = hdr.seq_number;
            offset_records[own].prior    = offset_records[own].later;
            offset_records[own].later    = offset_records[own].later
                                           + {16'h0, hdr.new_length} - {16'h0, hdr.old_length};
            rw.recorded = 1'b1;
         end
      end else begin
         if (seq_before(offset_records[own].position, hdr.seq_number))
            rw.new_seq = hdr.seq_number + offset_records[own].later;
         else
            rw.new_seq = hdr.seq_number + offset_records[own].prior;
         ack_back = hdr.ack_number - offset_records[peer].prior;
         if (seq_before(offset_records[peer].position, ack_back))
            rw.new_ack = hdr.ack_number - offset_records[peer].later;
         else
            rw.new_ack = ack_back;
         rw.new_checksum = csum_patch(hdr.old_checksum, hdr.ack_number, rw.new_ack);
         rw.new_checksum = csum_patch(rw.new_checksum, hdr.seq_number, rw.new_seq);
      end
      return rw;
   endfunction

   function automatic req_type make_header(logic op, logic [7:0] conn, logic dir,
                                           logic [31:0] seq, logic [31:0] ack,
                                           logic [15:0] chk, logic [15:0] olen,
                                           logic [15:0] nlen);
      req_type hdr;
      hdr.opcode       = op;
      hdr.conn_index   = conn;
      hdr.direction    = dir;
      hdr.seq_number   = seq;
      hdr.ack_number   = ack;
      hdr.old_checksum = chk;
      hdr.old_length   = olen;
      hdr.new_length   = nlen;
      return hdr;
   endfunction

   task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Driver: send queued headers, idle a drawn number of ready cycles after each
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap     <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (send_gap != 0) begin
            req_ch.valid <= 1'b0;
            if (req_ch.ready)
               send_gap <= send_gap - 1;
         end else if (pending_headers.size() != 0) begin
            req_item     <= pending_headers.pop_front();
            req_ch.valid <= 1'b1;
            send_gap     <= send_steady ? 0 : $urandom_range(0, 5);
            if ($urandom_range(0, 63) == 0)
               send_steady <= ~send_steady;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Predict the rewrite for every accepted header
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         due_rewrite = rewrite_header(req_item);
         expected_rewrites.push_back(due_rewrite);
         if (req_item.opcode == OP_ADJUST)
            adjust_count++;
         else if (due_rewrite.recorded)
            recorded_count++;
         else
            kept_count++;
      end
   end

   // Monitor: stall each result a drawn number of cycles, then check it
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      int      hold;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_wait    <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.new_seq, rsp_ch.new_ack, rsp_ch.new_checksum, rsp_ch.recorded};
         if (expected_rewrites.size() == 0) begin
            $display("%0t: result with nothing expected, actual %h", $time, got);
            fail_count++;
         end else begin
            want = expected_rewrites.pop_front();
            report_field("new_seq", want.new_seq, got.new_seq);
            report_field("new_ack", want.new_ack, got.new_ack);
            report_field("new_checksum", {16'h0, want.new_checksum}, {16'h0, got.new_checksum});
            report_field("recorded", {31'h0, want.recorded}, {31'h0, got.recorded});
         end
         hold = recv_steady ? 0 : $urandom_range(0, 5);
         if ($urandom_range(0, 63) == 0)
            recv_steady <= ~recv_steady;
         recv_wait    <= hold;
         rsp_ch.ready <= (hold == 0);
      end else if (recv_wait != 0) begin
         if (rsp_ch.valid) begin
            recv_wait    <= recv_wait - 1;
            rsp_ch.ready <= (recv_wait == 1);
         end
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("tcp_nat_seq_offset_tracker test failed");
         $finish;
      end
   end

   // Stimulus and end of run
   initial begin
      int          pick;
      int          delta;
      logic [7:0]  conn;
      logic        dir;
      logic [8:0]  own;
      logic [8:0]  peer;
      logic [15:0] olen;
      logic [15:0] nlen;

      for (int i = 0; i < 512; i++)
         offset_records[i] = '0;

      // Directed: unused record, stale and equal positions, extremes, wraparound
      pending_headers.push_back(make_header(OP_RESIZE, 8'd0, 1'b0, 32'd1000, 32'h0,
                                            16'h0, 16'd100, 16'd140));
      pending_headers.push_back(make_header(OP_RESIZE, 8'd0, 1'b0, 32'd900, 32'hFFFF_FFFF,
                                            16'hFFFF, 16'd10, 16'd20));
      pending_headers.push_back(make_header(OP_RESIZE, 8'd0, 1'b0, 32'd1000, 32'h0,
                                            16'h0, 16'd10, 16'd20));
      pending_headers.push_back(make_header(OP_ADJUST, 8'd0, 1'b0, 32'd999, 32'h0,
                                            16'h0, 16'h0, 16'h0));
      pending_headers.push_back(make_header(OP_ADJUST, 8'd0, 1'b0, 32'd1001, 32'h0,
                                            16'hFFFF, 16'hFFFF, 16'hFFFF));
      pending_headers.push_back(make_header(OP_ADJUST, 8'd0, 1'b1, 32'd0, 32'd1041,
                                            16'h1234, 16'h0, 16'h0));
      pending_headers.push_back(make_header(OP_ADJUST, 8'd0, 1'b1, 32'd5, 32'd1000,
                                            16'h8000, 16'h0, 16'h0));
      pending_headers.push_back(make_header(OP_RESIZE, 8'd0, 1'b0, 32'd2000, 32'h0,
                                            16'h0, 16'd140, 16'd140));
      pending_headers.push_back(make_header(OP_RESIZE, 8'd0, 1'b0, 32'd500, 32'h0,
                                            16'h0, 16'h0, 16'hFFFF));
      pending_headers.push_back(make_header(OP_ADJUST, 8'd0, 1'b0, 32'd501, 32'd7,
                                            16'h00FF, 16'h0, 16'h0));
      pending_headers.push_back(make_header(OP_RESIZE, 8'd255, 1'b1, 32'hFFFF_FFF0, 32'h0,
                                            16'h0, 16'hFFFF, 16'h0));
      pending_headers.push_back(make_header(OP_ADJUST, 8'd255, 1'b1, 32'h0000_0010,
                                            32'hFFFF_FFFF, 16'h1234, 16'h0, 16'h0));
      pending_headers.push_back(make_header(OP_ADJUST, 8'd255, 1'b0, 32'h7FFF_FFFF,
                                            32'h0000_0005, 16'hFFFF, 16'h0, 16'h0));
      pending_headers.push_back(make_header(OP_RESIZE, 8'd255, 1'b1, 32'h7FFF_FFF0, 32'h0,
                                            16'h0, 16'd1, 16'd3));
      pending_headers.push_back(make_header(OP_ADJUST, 8'd255, 1'b1, 32'h8000_0000,
                                            32'h7FFF_FFFF, 16'h0, 16'h0, 16'h0));
      pending_headers.push_back(make_header(OP_ADJUST, 8'd128, 1'b0, 32'h0, 32'h0,
                                            16'h0, 16'h0, 16'h0));
      pending_headers.push_back(make_header(OP_ADJUST, 8'd128, 1'b1, 32'hFFFF_FFFF,
                                            32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      pending_headers.push_back(make_header(OP_RESIZE, 8'd1, 1'b1, 32'hFFFF_FFFF,
                                            32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));

      // Random: mostly flows, half of them on a few busy connections, some noise
      for (int i = 0; i < 512; i++)
         flow_seq[i] = $urandom;
      for (int n = 0; n < RANDOM_HEADERS; n++) begin
         pick = $urandom_range(0, 99);
         conn = $urandom_range(0, 1) ? hot_conns[$urandom_range(0, 5)]
                                     : 8'($urandom_range(0, 255));
         dir  = 1'($urandom_range(0, 1));
         own  = {conn, dir};
         peer = {conn, ~dir};
         olen = 16'($urandom_range(0, 1500));
         delta = $urandom_range(0, 400);
         nlen = olen + delta[15:0] - 16'd200;
         if ($urandom_range(0, 9) == 0) begin
            olen = 16'($urandom_range(0, 65535));
            nlen = 16'($urandom_range(0, 65535));
         end
         if (pick < 15) begin
            pending_headers.push_back(make_header(1'($urandom_range(0, 1)),
                                                  8'($urandom_range(0, 255)),
                                                  1'($urandom_range(0, 1)), $urandom, $urandom,
                                                  16'($urandom_range(0, 65535)),
                                                  16'($urandom_range(0, 65535)),
                                                  16'($urandom_range(0, 65535))));
         end else if (pick < 40) begin
            // Resize at the flow cursor, then move the cursor forward
            pending_headers.push_back(make_header(OP_RESIZE, conn, dir, flow_seq[own], $urandom,
                                                  16'($urandom_range(0, 65535)), olen, nlen));
            flow_seq[own] = flow_seq[own] + $urandom_range(1, 4000);
         end else if (pick < 48) begin
            // Retransmitted resize behind the cursor
            pending_headers.push_back(make_header(OP_RESIZE, conn, dir,
                                                  flow_seq[own] - $urandom_range(1, 4000),
                                                  $urandom, 16'($urandom_range(0, 65535)),
                                                  olen, nlen));
         end else begin
            // Adjust near both cursors so positions fall on either side
            pending_headers.push_back(make_header(OP_ADJUST, conn, dir,
                                                  flow_seq[own] + $urandom_range(0, 8000) - 4000,
                                                  flow_seq[peer] + $urandom_range(0, 8000) - 4000,
                                                  16'($urandom_range(0, 65535)),
                                                  16'($urandom_range(0, 65535)),
                                                  16'($urandom_range(0, 65535))));
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Drain: wait for every header to be sent and every rewrite to return
      while (pending_headers.size() != 0 || req_ch.valid || expected_rewrites.size() != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);

      $display("Covered %0d adjusts, %0d resizes recorded, %0d resizes left unchanged",
               adjust_count, recorded_count, kept_count);
      $display("Mismatches found: %0d", fail_count);
      if (fail_count == 0)
         $display("tcp_nat_seq_offset_tracker test passed");
      else
         $display("tcp_nat_seq_offset_tracker test failed");
      $finish;
   end

endmodule
